### rtl/core/mck_pkg.sv
// ----------------------------------------------------------------------------
// Morse keyer package
// Shared types, character codes and the symbol table for the keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned UNIT_W     = 16;
   localparam int unsigned DUR_W      = 19;
   localparam int unsigned MULT_W     = 3;
   localparam int unsigned MAX_SYMS   = 6;
   localparam int unsigned LEN_W      = 3;
   localparam int unsigned NUM_CODES  = 40;
   localparam int unsigned IDX_W      = 6;

   localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd250;

   // ASCII codes used by the lookup
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PERIOD  = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_QUEST   = 8'h3F;
   localparam logic [CHAR_W-1:0] CHAR_BANG    = 8'h21;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

   localparam logic [IDX_W-1:0] IDX_DIGIT  = 6'd26;
   localparam logic [IDX_W-1:0] IDX_PERIOD = 6'd36;
   localparam logic [IDX_W-1:0] IDX_COMMA  = 6'd37;
   localparam logic [IDX_W-1:0] IDX_QUEST  = 6'd38;
   localparam logic [IDX_W-1:0] IDX_BANG   = 6'd39;

   // Element durations in units
   localparam logic [MULT_W-1:0] UNITS_DOT   = 3'd1;
   localparam logic [MULT_W-1:0] UNITS_DASH  = 3'd3;
   localparam logic [MULT_W-1:0] UNITS_GAP   = 3'd1;
   localparam logic [MULT_W-1:0] UNITS_TAIL  = 3'd3;
   localparam logic [MULT_W-1:0] UNITS_SPACE = 3'd5;
   localparam logic [MULT_W-1:0] UNITS_NONE  = 3'd0;

   typedef enum logic [1:0] {
      CLASS_SYMBOLS,
      CLASS_SPACE,
      CLASS_BAD
   } char_class_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_MARK,
      EMIT_GAP,
      EMIT_TAIL,
      EMIT_SPACE,
      EMIT_BAD
   } emit_kind_type;

   // Symbols left-aligned, first symbol in the MSB, 1 = dash
   typedef struct packed {
      logic [LEN_W-1:0]    len;
      logic [MAX_SYMS-1:0] pattern;
   } sym_entry_type;

   typedef struct packed {
      char_class_type      char_class;
      logic [LEN_W-1:0]    len;
      logic [MAX_SYMS-1:0] pattern;
   } lookup_type;

   typedef struct packed {
      logic          load;
      logic          advance;
      emit_kind_type emit_kind;
   } mck_cmd_type;

   typedef struct packed {
      char_class_type char_class;
      logic           last_sym;
   } mck_status_type;

   localparam sym_entry_type SYM_TABLE [NUM_CODES] = '{
      '{3'd2, 6'b010000}, '{3'd4, 6'b100000}, '{3'd4, 6'b101000}, // a b c
      '{3'd3, 6'b100000}, '{3'd1, 6'b000000}, '{3'd4, 6'b001000}, // d e f
      '{3'd3, 6'b110000}, '{3'd4, 6'b000000}, '{3'd2, 6'b000000}, // g h i
      '{3'd4, 6'b011100}, '{3'd3, 6'b101000}, '{3'd4, 6'b010000}, // j k l
      '{3'd2, 6'b110000}, '{3'd2, 6'b100000}, '{3'd3, 6'b111000}, // m n o
      '{3'd4, 6'b011000}, '{3'd4, 6'b110100}, '{3'd3, 6'b010000}, // p q r
      '{3'd3, 6'b000000}, '{3'd1, 6'b100000}, '{3'd3, 6'b001000}, // s t u
      '{3'd4, 6'b000100}, '{3'd3, 6'b011000}, '{3'd4, 6'b100100}, // v w x
      '{3'd4, 6'b101100}, '{3'd4, 6'b110000},                     // y z
      '{3'd5, 6'b111110}, '{3'd5, 6'b011110}, '{3'd5, 6'b001110}, // 0 1 2
      '{3'd5, 6'b000110}, '{3'd5, 6'b000010}, '{3'd5, 6'b000000}, // 3 4 5
      '{3'd5, 6'b100000}, '{3'd5, 6'b110000}, '{3'd5, 6'b111000}, // 6 7 8
      '{3'd5, 6'b111100},                                         // 9
      '{3'd6, 6'b000000}, '{3'd6, 6'b010101},                     // . ,
      '{3'd6, 6'b001100}, '{3'd6, 6'b110011}                      // ? !
   };

   function automatic lookup_type mck_lookup(input logic [CHAR_W-1:0] c);
      lookup_type       res;
      logic [IDX_W-1:0] idx;
      logic             hit;
      logic [CHAR_W-1:0] off_a;
      logic [CHAR_W-1:0] off_0;
      off_a = c - CHAR_LOWER_A;
      off_0 = c - CHAR_DIGIT_0;
      hit   = 1'b1;
      idx   = '0;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         idx = off_a[IDX_W-1:0];
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         idx = IDX_DIGIT + off_0[IDX_W-1:0];
      end else if (c == CHAR_PERIOD) begin
         idx = IDX_PERIOD;
      end else if (c == CHAR_COMMA) begin
         idx = IDX_COMMA;
      end else if (c == CHAR_QUEST) begin
         idx = IDX_QUEST;
      end else if (c == CHAR_BANG) begin
         idx = IDX_BANG;
      end else begin
         hit = 1'b0;
      end
      res.len     = SYM_TABLE[idx].len;
      res.pattern = SYM_TABLE[idx].pattern;
      if (c == CHAR_SPACE) begin
         res.char_class = CLASS_SPACE;
      end else if (hit) begin
         res.char_class = CLASS_SYMBOLS;
      end else begin
         res.char_class = CLASS_BAD;
      end
      return res;
   endfunction

endpackage

### rtl/core/morse_character_keyer.sv
// ----------------------------------------------------------------------------
// Morse character keyer
// Expands one character word into a run of timed LED key elements.
// ----------------------------------------------------------------------------
// A character is taken when start is high while busy is low. Letters a-z,
// digits, . , ? ! give dot and dash marks with one-unit gaps between them and
// a three-unit off element at the end; a space gives one five-unit off
// element; any other code gives one word with rsp_bad_char set and zero
// duration. Each element is one rsp_ word, shown for exactly one cycle with
// rsp_valid high; the receiver cannot stall, so it must take every strobe.
// Within a character, elements come out one per cycle; the accepting edge
// moves the controller out of idle, and each element then passes through
// the result register. A character of n symbols (six at most, for the
// punctuation) keeps busy high through n marks, n-1 gaps and the tail, one
// element per state of the controller; space and bad codes use one state.
// rsp_last marks the final element of each character. The unit length
// (csr_unit_ticks, reset 250) is written through the csr_ port, which is
// always ready; write it only while busy is low and no element is pending.
// ----------------------------------------------------------------------------
module morse_character_keyer import mck_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // character request
   input  logic                start,
   output logic                busy,
   input  logic [CHAR_W-1:0]   req_char_code,
   // unit length register
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [UNIT_W-1:0]   csr_unit_ticks,
   // element results
   output logic                rsp_valid,
   output logic                rsp_led_on,
   output logic [DUR_W-1:0]    rsp_duration_ticks,
   output logic                rsp_bad_char,
   output logic                rsp_last
);

   mck_cmd_type    cmd;
   mck_status_type status;

   // register is writable at any time; users keep writes to idle periods
   assign csr_ready = 1'b1;

   // sequencer: IDLE -> MARK (-> GAP -> MARK)* -> TAIL, or SPACE / BAD
   mck_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // symbol shifter, unit register, duration product and result register
   mck_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_char_code      (req_char_code),
      .csr_write          (csr_valid & csr_ready),
      .csr_unit_ticks     (csr_unit_ticks),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_led_on         (rsp_led_on),
      .rsp_duration_ticks (rsp_duration_ticks),
      .rsp_bad_char       (rsp_bad_char),
      .rsp_last           (rsp_last)
   );

`ifndef SYNTHESIS
   // a taken character always starts a run
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("keyer not busy after accepting a character");

   // final element comes out as the controller returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("last element shown while still busy");

   // a bad code gives one dark, zero-length, final word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_char) |->
         (rsp_last && !rsp_led_on && rsp_duration_ticks == '0))
      else $error("bad character word malformed");

   // every run ends dark: a mark is never the final element
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_led_on) |-> !rsp_last)
      else $error("mark element flagged as last");

   // strobes only follow an accepted character
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(busy)) |-> $past(start))
      else $error("result strobe without a character");
`endif

endmodule

### rtl/core/mck_ctrl.sv
// ----------------------------------------------------------------------------
// Morse keyer controller
// Walks one character through mark, gap and tail elements.
// ----------------------------------------------------------------------------
module mck_ctrl import mck_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  mck_status_type status,
   output mck_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_GAP,
      ST_TAIL,
      ST_SPACE,
      ST_BAD
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.advance   = 1'b0;
      cmd.emit_kind = EMIT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (status.char_class)
                  CLASS_SPACE: state_in = ST_SPACE;
                  CLASS_BAD:   state_in = ST_BAD;
                  default:     state_in = ST_MARK;
               endcase
            end
         end
         ST_MARK: begin
            cmd.emit_kind = EMIT_MARK;
            state_in      = status.last_sym ? ST_TAIL : ST_GAP;
         end
         ST_GAP: begin
            cmd.emit_kind = EMIT_GAP;
            cmd.advance   = 1'b1;
            state_in      = ST_MARK;
         end
         ST_TAIL: begin
            cmd.emit_kind = EMIT_TAIL;
            state_in      = ST_IDLE;
         end
         ST_SPACE: begin
            cmd.emit_kind = EMIT_SPACE;
            state_in      = ST_IDLE;
         end
         ST_BAD: begin
            cmd.emit_kind = EMIT_BAD;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/core/mck_datapath.sv
// ----------------------------------------------------------------------------
// Morse keyer datapath
// Symbol shift register, unit length register and the result register.
// ----------------------------------------------------------------------------
module mck_datapath import mck_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic                csr_write,
   input  logic [UNIT_W-1:0]   csr_unit_ticks,
   input  mck_cmd_type         cmd,
   output mck_status_type      status,
   output logic                rsp_valid,
   output logic                rsp_led_on,
   output logic [DUR_W-1:0]    rsp_duration_ticks,
   output logic                rsp_bad_char,
   output logic                rsp_last
);

   lookup_type          lookup_w;
   logic [MAX_SYMS-1:0] pattern_ff;
   logic [LEN_W-1:0]    remain_ff;
   logic [UNIT_W-1:0]   unit_ff;
   logic [MULT_W-1:0]   units_w;
   logic                led_in;
   logic                bad_in;
   logic                last_in;
   logic [DUR_W-1:0]    dur_in;
   logic                valid_ff;
   logic                led_ff;
   logic [DUR_W-1:0]    dur_ff;
   logic                bad_ff;
   logic                last_ff;

   assign lookup_w          = mck_lookup(req_char_code);
   assign status.char_class = lookup_w.char_class;
   assign status.last_sym   = (remain_ff == '0);

   // next element from the command
   always_comb begin
      units_w = UNITS_NONE;
      led_in  = 1'b0;
      bad_in  = 1'b0;
      last_in = 1'b0;
      unique case (cmd.emit_kind)
         EMIT_MARK: begin
            led_in  = 1'b1;
            units_w = pattern_ff[MAX_SYMS-1] ? UNITS_DASH : UNITS_DOT;
         end
         EMIT_GAP:   units_w = UNITS_GAP;
         EMIT_TAIL: begin
            units_w = UNITS_TAIL;
            last_in = 1'b1;
         end
         EMIT_SPACE: begin
            units_w = UNITS_SPACE;
            last_in = 1'b1;
         end
         EMIT_BAD: begin
            bad_in  = 1'b1;
            last_in = 1'b1;
         end
         default: units_w = UNITS_NONE;
      endcase
   end

   // small 16x3 product, fits 19 bits
   assign dur_in = {{(DUR_W-UNIT_W){1'b0}}, unit_ff} * {{(DUR_W-MULT_W){1'b0}}, units_w};

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff  <= UNIT_RESET;
         valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unit_ff <= csr_unit_ticks;
         end
         valid_ff <= (cmd.emit_kind != EMIT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pattern_ff <= lookup_w.pattern;
         remain_ff  <= lookup_w.len - 3'd1;
      end else if (cmd.advance) begin
         pattern_ff <= {pattern_ff[MAX_SYMS-2:0], 1'b0};
         remain_ff  <= remain_ff - 3'd1;
      end
      led_ff  <= led_in;
      dur_ff  <= dur_in;
      bad_ff  <= bad_in;
      last_ff <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_led_on         = led_ff;
   assign rsp_duration_ticks = dur_ff;
   assign rsp_bad_char       = bad_ff;
   assign rsp_last           = last_ff;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse keyer testbench
// Sends character words through the start/busy port and checks every key
// element on the rsp_ strobe against a local model of the keyer. The unit
// length is rewritten between phases, only while the keyer is idle.
// ----------------------------------------------------------------------------
module testbench;
   import mck_pkg::*;

   // one key element as it leaves the keyer
   typedef struct packed {
      logic             led_on;
      logic [DUR_W-1:0] duration_ticks;
      logic             bad_char;
      logic             last;
   } key_elem_type;

   // directed rows either key a character or rewrite the unit length
   typedef enum logic {
      ROW_CHAR,
      ROW_UNIT
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  value;    // character code or new unit length
      logic         pinned;   // 1: the single element below is the answer
      key_elem_type elem;
   } stim_row_type;

   localparam key_elem_type NO_PIN   = '0;
   localparam key_elem_type BAD_ELEM = '{1'b0, 19'd0, 1'b1, 1'b1};
   localparam int           NUM_DIRECTED = 27;
   localparam int           RANDOM_PHASES = 4;
   localparam int           ITEMS_PER_PHASE = 39;

   // Hand-checked answers only where one element says it all: spaces at
   // several unit lengths and codes with no Morse entry. Every other row goes
   // through the model below.
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      '{ROW_CHAR, 16'h0020, 1'b1, '{1'b0, 19'd1250, 1'b0, 1'b1}}, // space, reset unit
      '{ROW_CHAR, 16'h0041, 1'b1, BAD_ELEM},                       // uppercase A
      '{ROW_CHAR, 16'h0000, 1'b1, BAD_ELEM},
      '{ROW_CHAR, 16'h00FF, 1'b1, BAD_ELEM},
      '{ROW_CHAR, 16'h0061, 1'b0, NO_PIN},                         // a
      '{ROW_CHAR, 16'h007A, 1'b0, NO_PIN},                         // z
      '{ROW_CHAR, 16'h0030, 1'b0, NO_PIN},                         // 0
      '{ROW_CHAR, 16'h0039, 1'b0, NO_PIN},                         // 9
      '{ROW_CHAR, 16'h002E, 1'b0, NO_PIN},                         // period
      '{ROW_CHAR, 16'h002C, 1'b0, NO_PIN},                         // comma
      '{ROW_CHAR, 16'h003F, 1'b0, NO_PIN},                         // ?
      '{ROW_CHAR, 16'h0021, 1'b0, NO_PIN},                         // !
      '{ROW_CHAR, 16'h0066, 1'b0, NO_PIN},                         // f, repaired entry
      '{ROW_CHAR, 16'h0070, 1'b0, NO_PIN},                         // p, repaired entry
      '{ROW_UNIT, 16'hFFFF, 1'b0, NO_PIN},
      '{ROW_CHAR, 16'h0020, 1'b1, '{1'b0, 19'd327675, 1'b0, 1'b1}}, // widest duration
      '{ROW_CHAR, 16'h0021, 1'b0, NO_PIN},
      '{ROW_UNIT, 16'h0000, 1'b0, NO_PIN},                         // zero unit length
      '{ROW_CHAR, 16'h0020, 1'b1, '{1'b0, 19'd0, 1'b0, 1'b1}},
      '{ROW_CHAR, 16'h0071, 1'b0, NO_PIN},                         // q
      '{ROW_CHAR, 16'h0060, 1'b1, BAD_ELEM},                       // just below a
      '{ROW_UNIT, 16'h0001, 1'b0, NO_PIN},
      '{ROW_CHAR, 16'h0020, 1'b1, '{1'b0, 19'd5, 1'b0, 1'b1}},
      '{ROW_CHAR, 16'h0035, 1'b0, NO_PIN},                         // 5
      '{ROW_CHAR, 16'h007B, 1'b1, BAD_ELEM},                       // just above z
      '{ROW_CHAR, 16'h002F, 1'b1, BAD_ELEM},                       // just below 0
      '{ROW_CHAR, 16'h003A, 1'b1, BAD_ELEM}                        // just above 9
   };

   // a-z, 0-9, then . , ? !   ('-' is a dash)
   string morse_patterns [40] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
      "..-", "...-", ".--", "-..-", "-.--", "--..",
      "-----", ".----", "..---", "...--", "....-",
      ".....", "-....", "--...", "---..", "----.",
      "......", ".-.-.-", "..--..", "--..--"
   };

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [CHAR_W-1:0] req_char_code;
   logic              csr_valid;
   logic              csr_ready;
   logic [UNIT_W-1:0] csr_unit_ticks;
   logic              rsp_valid;
   logic              rsp_led_on;
   logic [DUR_W-1:0]  rsp_duration_ticks;
   logic              rsp_bad_char;
   logic              rsp_last;

   // driver -> checker: a hand-typed answer for the word now on req_
   logic              pin_next;
   key_elem_type      pin_elem;

   logic [UNIT_W-1:0] unit_len;       // checker's copy of the register
   key_elem_type      due_elems [$];  // elements still owed by the keyer
   int                fail_count;
   bit                idle_ok;

   morse_character_keyer dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_char_code      (req_char_code),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_unit_ticks     (csr_unit_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_led_on         (rsp_led_on),
      .rsp_duration_ticks (rsp_duration_ticks),
      .rsp_bad_char       (rsp_bad_char),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // generous cap, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endfunction

   function automatic key_elem_type make_elem(input bit on, input int units, input bit bad,
                                              input bit fin);
      key_elem_type e;
      e.led_on         = on;
      e.duration_ticks = DUR_W'(units * int'(unit_len));
      e.bad_char       = bad;
      e.last           = fin;
      return e;
   endfunction

   // table slot for a code, -1 when it has no Morse entry
   function automatic int symbol_slot(input logic [CHAR_W-1:0] c);
      if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61;
      if (c >= 8'h30 && c <= 8'h39) return 26 + int'(c) - 'h30;
      if (c == 8'h2E) return 36;
      if (c == 8'h2C) return 37;
      if (c == 8'h3F) return 38;
      if (c == 8'h21) return 39;
      return -1;
   endfunction

   // expand one character into the elements it should key
   function automatic void key_character(input logic [CHAR_W-1:0] c);
      int    slot;
      string pat;
      slot = symbol_slot(c);
      if (c == 8'h20) begin
         due_elems.push_back(make_elem(1'b0, 5, 1'b0, 1'b1));
      end else if (slot < 0) begin
         due_elems.push_back(BAD_ELEM);
      end else begin
         pat = morse_patterns[slot];
         for (int i = 0; i < pat.len(); i++) begin
            if (i > 0) due_elems.push_back(make_elem(1'b1 ^ 1'b1, 1, 1'b0, 1'b0));
            due_elems.push_back(make_elem(1'b1, (pat[i] == "-") ? 3 : 1, 1'b0, 1'b0));
         end
         due_elems.push_back(make_elem(1'b0, 3, 1'b0, 1'b1)); // character tail
      end
   endfunction

   // Checker: track the register, expand each taken word, compare each strobe.
   // All of it samples pre-edge values, so order within the step is moot.
   always @(posedge clock) begin
      key_elem_type want;
      if (reset) begin
         unit_len = 16'd250;
      end else begin
         if (csr_valid && csr_ready) begin
            unit_len = csr_unit_ticks;
         end
         if (start && !busy) begin
            if (pin_next) due_elems.push_back(pin_elem);
            else key_character(req_char_code);
         end
         if (rsp_valid) begin
            if (due_elems.size() == 0) begin
               note_failure($sformatf("nothing owed: led=%0b dur=%0d bad=%0b last=%0b",
                            rsp_led_on, rsp_duration_ticks, rsp_bad_char, rsp_last));
            end else begin
               want = due_elems.pop_front();
               if (rsp_led_on !== want.led_on || rsp_duration_ticks !== want.duration_ticks ||
                   rsp_bad_char !== want.bad_char || rsp_last !== want.last) begin
                  note_failure($sformatf(
                     "mismatch: want %0b/%0d/%0b/%0b got %0b/%0d/%0b/%0b",
                     want.led_on, want.duration_ticks, want.bad_char, want.last,
                     rsp_led_on, rsp_duration_ticks, rsp_bad_char, rsp_last));
               end
            end
         end
      end
   end

   // Present one character and hold it until the keyer takes it. start stays
   // high after the taking edge; the next call lowers it only if it idles.
   task automatic send_char(input logic [CHAR_W-1:0] code, input logic pin,
                            input key_elem_type answer);
      if (idle_ok) begin
         while ($urandom_range(99) < 22) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start         <= 1'b1;
      req_char_code <= code;
      pin_next      <= pin;
      pin_elem      <= answer;
      do @(posedge clock); while (busy);
   endtask

   // wait out every owed element, then the keyer's short tail
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (due_elems.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_unit(input logic [UNIT_W-1:0] value);
      drain();
      csr_valid      <= 1'b1;
      csr_unit_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly real characters, some spaces, the rest any byte at all
   function automatic logic [CHAR_W-1:0] pick_char;
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return CHAR_W'('h61 + $urandom_range(25));
      if (roll < 70) return CHAR_W'('h30 + $urandom_range(9));
      if (roll < 78) begin
         case ($urandom_range(3))
            0: return CHAR_PERIOD;
            1: return CHAR_COMMA;
            2: return CHAR_QUEST;
            default: return CHAR_BANG;
         endcase
      end
      if (roll < 86) return CHAR_SPACE;
      return CHAR_W'($urandom_range(255));
   endfunction

   initial begin
      logic [UNIT_W-1:0] phase_unit;
      fail_count      = 0;
      idle_ok         = 1'b1;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_char_code  <= '0;
      csr_valid      <= 1'b0;
      csr_unit_ticks <= '0;
      pin_next       <= 1'b0;
      pin_elem       <= NO_PIN;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_DIRECTED; r++) begin
         if (DIRECTED[r].kind == ROW_UNIT) begin
            write_unit(DIRECTED[r].value[UNIT_W-1:0]);
         end else begin
            send_char(DIRECTED[r].value[CHAR_W-1:0], DIRECTED[r].pinned, DIRECTED[r].elem);
         end
      end

      // random phases: full-range unit, widest unit (no idling), unit of one, full-range again
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            1: phase_unit = 16'hFFFF;
            2: phase_unit = 16'h0001;
            default: phase_unit = UNIT_W'($urandom_range(65535));
         endcase
         write_unit(phase_unit);
         idle_ok = (ph != 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_char(pick_char(), 1'b0, NO_PIN);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (due_elems.size() != 0) begin
         note_failure($sformatf("%0d elements never keyed", due_elems.size()));
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
